@@ hw/rtl/pfba_pkg.sv @@
// Shared constants, codes and control types of the page frame bitmap allocator.
`default_nettype none

package pfba_pkg;

   // Default geometry of the bitmap and of one page.
   localparam int unsigned BITMAP_WORDS_DEF = 1024;
   localparam int unsigned PAGE_SHIFT_DEF   = 12;

   // Fixed address map.
   localparam logic [31:0] PAGE_BASE = 32'h0010_0000;
   localparam logic [31:0] ALL_USED  = 32'hFFFF_FFFF;

   // Field widths.
   localparam int unsigned FUNC_W   = 2;
   localparam int unsigned ADDR_W   = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned PAGE_W   = 16;
   localparam int unsigned BIT_W    = 5;
   localparam int unsigned WORD_W   = 32;

   // Item kinds.
   localparam logic [FUNC_W-1:0] FN_MARK_USED  = 2'd0;
   localparam logic [FUNC_W-1:0] FN_MARK_FREE  = 2'd1;
   localparam logic [FUNC_W-1:0] FN_MARK_RANGE = 2'd2;
   localparam logic [FUNC_W-1:0] FN_ALLOC      = 2'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STS_ALIGN = 2'd1;
   localparam logic [STATUS_W-1:0] STS_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] STS_FULL  = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic load;
      logic check;
      logic walk;
      logic rsp_load;
   } pfba_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic need_walk;
      logic walk_done;
   } pfba_stat_type;

endpackage

`default_nettype wire

@@ hw/rtl/pfba_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module pfba_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/pfba_datapath.sv @@
// Datapath: item and result registers, address checks, bitmap RAM and word walker.
`default_nettype none

module pfba_datapath
   import pfba_pkg::*;
#(
   parameter int unsigned BITMAP_WORDS = BITMAP_WORDS_DEF,
   parameter int unsigned PAGE_SHIFT   = PAGE_SHIFT_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pfba_cmd_type         cmd,
   output pfba_stat_type             stat,
   input  wire logic [FUNC_W-1:0]    req_func,
   input  wire logic [ADDR_W-1:0]    req_phys_addr,
   input  wire logic [ADDR_W-1:0]    req_end_addr,
   input  wire logic                 csr_valid,
   input  wire logic [PAGE_W-1:0]    csr_data,
   output logic      [ADDR_W-1:0]    rsp_page_addr,
   output logic      [STATUS_W-1:0]  rsp_status
);

   localparam int unsigned WA_W   = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
   localparam int unsigned WIDX_W = WA_W + 1;
   localparam logic [31:0] CAP    = 32'(BITMAP_WORDS * 32);
   localparam logic [31:0] ADDRESSABLE = ((ALL_USED - PAGE_BASE) >> PAGE_SHIFT) + 32'd1;
   localparam logic [31:0] LIMIT  = (CAP < ADDRESSABLE) ? CAP : ADDRESSABLE;
   localparam logic [WIDX_W-1:0] CLEAR_END = WIDX_W'(BITMAP_WORDS - 1);

   // Configuration and item registers.
   logic [PAGE_W-1:0]   managed_ff;
   logic [FUNC_W-1:0]   func_ff;
   logic [ADDR_W-1:0]   a_ff;
   logic [ADDR_W-1:0]   e_ff;

   // Walk bounds and results.
   logic [WIDX_W-1:0]   first_ff, first_in;
   logic [WIDX_W-1:0]   last_ff, last_in;
   logic [BIT_W-1:0]    lo_ff, lo_in;
   logic [BIT_W-1:0]    hi_ff, hi_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [WIDX_W-1:0]   ptr_ff, ptr_in;
   logic                dat_vld_ff, dat_vld_in;
   logic [WIDX_W-1:0]   dat_idx_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   // Effective page count.
   logic [PAGE_W-1:0]   eff;
   assign eff = ({16'b0, managed_ff} < LIMIT) ? managed_ff : LIMIT[PAGE_W-1:0];

   // Address checks.
   logic                a_mis, e_mis, a_in, e_in, chk_walk;
   logic [ADDR_W-1:0]   a_num, e_num;
   logic [PAGE_W-1:0]   pa, pe;
   logic [PAGE_W:0]     words;
   logic [STATUS_W-1:0] chk_status;

   assign a_mis = |a_ff[PAGE_SHIFT-1:0];
   assign e_mis = |e_ff[PAGE_SHIFT-1:0];
   assign a_num = (a_ff - PAGE_BASE) >> PAGE_SHIFT;
   assign e_num = (e_ff - PAGE_BASE) >> PAGE_SHIFT;
   assign a_in  = (a_ff >= PAGE_BASE) && (a_num < {16'b0, eff});
   assign e_in  = (e_ff >= PAGE_BASE) && (e_num < {16'b0, eff});
   assign pa    = a_num[PAGE_W-1:0];
   assign pe    = e_num[PAGE_W-1:0];
   assign words = ({1'b0, eff} + (PAGE_W+1)'(31)) >> BIT_W;

   always_comb begin
      chk_status = STS_OK;
      chk_walk   = 1'b0;
      first_in   = WIDX_W'(pa >> BIT_W);
      last_in    = WIDX_W'(pa >> BIT_W);
      lo_in      = pa[BIT_W-1:0];
      hi_in      = pa[BIT_W-1:0];
      unique case (func_ff) inside
         FN_MARK_USED, FN_MARK_FREE: begin
            if (a_mis) begin
               chk_status = STS_ALIGN;
            end else if (!a_in) begin
               chk_status = STS_RANGE;
            end else begin
               chk_walk = 1'b1;
            end
         end
         FN_MARK_RANGE: begin
            last_in = WIDX_W'(pe >> BIT_W);
            hi_in   = pe[BIT_W-1:0];
            if (a_mis || e_mis || (a_ff > e_ff)) begin
               chk_status = STS_ALIGN;
            end else if (!a_in || !e_in) begin
               chk_status = STS_RANGE;
            end else begin
               chk_walk = 1'b1;
            end
         end
         default: begin
            // Allocate: provisional full status, cleared when a free page turns up.
            first_in   = '0;
            last_in    = WIDX_W'(words - (PAGE_W+1)'(1));
            lo_in      = '0;
            hi_in      = '1;
            chk_status = STS_FULL;
            chk_walk   = (eff != '0);
         end
      endcase
   end

   // Word walker: one read issued per cycle, modify and write in the following cycle.
   logic              issue;
   logic [WORD_W-1:0] old_word, new_word, mask, avail, valid_mask, low_bit;
   logic [BIT_W-1:0]  lo_eff, hi_eff, free_k, eff_lo;
   logic              found, is_alloc, walk_wr;
   logic              ram_wr_en, ram_rd_en;
   logic [WA_W-1:0]   ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;

   assign is_alloc = (func_ff == FN_ALLOC);
   assign issue    = cmd.walk && (ptr_ff <= last_ff);
   assign eff_lo   = eff[BIT_W-1:0];

   always_comb begin
      lo_eff = (dat_idx_ff == first_ff) ? lo_ff : '0;
      hi_eff = (dat_idx_ff == last_ff) ? hi_ff : '1;
      mask   = (ALL_USED << lo_eff) & (ALL_USED >> (5'd31 - hi_eff));
      // Pages past the managed count in the last word count as used.
      if ((dat_idx_ff == last_ff) && (eff_lo != '0)) begin
         valid_mask = ~(ALL_USED << eff_lo);
      end else begin
         valid_mask = ALL_USED;
      end
      avail   = ~old_word & valid_mask;
      low_bit = avail & (~avail + 32'd1);
      free_k  = '0;
      for (int k = 0; k < WORD_W; k++) begin
         if (low_bit[k]) begin
            free_k = free_k | BIT_W'(k);
         end
      end
      found = is_alloc && (avail != '0);
      if (is_alloc) begin
         new_word = old_word | low_bit;
      end else if (func_ff == FN_MARK_FREE) begin
         new_word = old_word & ~mask;
      end else begin
         new_word = old_word | mask;
      end
   end

   assign walk_wr     = cmd.walk && dat_vld_ff && (!is_alloc || found);
   assign ram_wr_en   = cmd.clear || walk_wr;
   assign ram_wr_addr = cmd.clear ? ptr_ff[WA_W-1:0] : dat_idx_ff[WA_W-1:0];
   assign ram_wr_data = cmd.clear ? '0 : new_word;
   assign ram_rd_en   = issue;

   pfba_ram #(
      .WIDTH (WORD_W),
      .DEPTH (BITMAP_WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ptr_ff[WA_W-1:0]),
      .rd_data (old_word)
   );

   always_comb begin
      ptr_in     = ptr_ff;
      dat_vld_in = issue;
      status_in  = status_ff;
      addr_in    = addr_ff;
      if (cmd.clear) begin
         ptr_in = ptr_ff + WIDX_W'(1);
      end else if (cmd.check) begin
         ptr_in     = first_in;
         dat_vld_in = 1'b0;
         status_in  = chk_status;
         addr_in    = '0;
      end else if (issue) begin
         ptr_in = ptr_ff + WIDX_W'(1);
      end
      if (cmd.walk && dat_vld_ff && found) begin
         status_in = STS_OK;
         addr_in   = PAGE_BASE + (ADDR_W'({dat_idx_ff, free_k}) << PAGE_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         managed_ff <= '0;
         ptr_ff     <= '0;
         dat_vld_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            managed_ff <= csr_data;
         end
         ptr_ff     <= ptr_in;
         dat_vld_ff <= dat_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         a_ff    <= req_phys_addr;
         e_ff    <= req_end_addr;
      end
      if (cmd.check) begin
         first_ff <= first_in;
         last_ff  <= last_in;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
      end
      if (issue) begin
         dat_idx_ff <= ptr_ff;
      end
      status_ff <= status_in;
      addr_ff   <= addr_in;
      if (cmd.rsp_load) begin
         rsp_addr_ff   <= addr_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign stat.clear_last = (ptr_ff == CLEAR_END);
   assign stat.need_walk  = chk_walk;
   assign stat.walk_done  = dat_vld_ff && (found || (dat_idx_ff == last_ff));

   assign rsp_page_addr = rsp_addr_ff;
   assign rsp_status    = rsp_status_ff;

   a_dat_bound: assert property (@(posedge clock) disable iff (reset)
      dat_vld_ff |-> (dat_idx_ff <= last_ff))
      else $error("bitmap word in flight lies past the walk end");

   a_alloc_addr: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load && is_alloc && (status_ff == STS_OK)) |->
         ((addr_ff[PAGE_SHIFT-1:0] == '0) && (addr_ff >= PAGE_BASE)))
      else $error("allocated address is misaligned or below base");

   a_mark_addr: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load && !is_alloc) |-> (addr_ff == '0))
      else $error("non-allocate result carries a page address");

endmodule

`default_nettype wire

@@ hw/rtl/pfba_ctrl.sv @@
// Controller state machine: clearing sweep, item intake, check, walk and result hand-off.
`default_nettype none

module pfba_ctrl
   import pfba_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   input  wire pfba_stat_type stat,
   output pfba_cmd_type       cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = stat.need_walk ? ST_WALK : ST_DONE;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (stat.walk_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_CHECK))
      else $error("accepted word did not move to the check step");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside the done step");

   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("result pending during bitmap clearing");

endmodule

`default_nettype wire

@@ hw/rtl/page_frame_bitmap_allocator_unit.sv @@
// Top level of the page frame bitmap allocator: controller plus datapath.
//
// The unit tracks page frames above a base of 1 MiB with one used bit per page,
// held in a RAM of BITMAP_WORDS words of 32 bits. A request word on the req_
// stream carries the operation kind in tuser and the two addresses in tdata.
// Every request produces exactly one response word on the rsp_ stream with the
// allocated address (zero unless an allocation succeeded) and a status code.
// The csr_ channel writes the managed page count and is always ready; write it
// only while no request is in flight.
// After reset the unit sweeps the bitmap RAM to zero, one word per cycle, across
// all BITMAP_WORDS words; req_tready stays low during the sweep.
// Requests are handled one at a time. A rejected request, or an allocation with
// no page managed, goes from the check step straight to the done step. Single
// page marks, range marks and allocations walk the RAM one word per cycle over
// the words they touch; allocation stops at the first word with a free page,
// at worst after BITMAP_WORDS words. The unit is ready for the next request in
// the same cycle as the response is raised.
// The response sits in an output register: while the receiver stalls, the unit
// still accepts and processes the next request and holds its result until the
// register frees.
`default_nettype none

module page_frame_bitmap_allocator_unit
   import pfba_pkg::*;
#(
   parameter int unsigned BITMAP_WORDS = BITMAP_WORDS_DEF,
   parameter int unsigned PAGE_SHIFT   = PAGE_SHIFT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [31:0] phys_addr, [63:32] end_addr
   input  wire logic [1:0]  req_tuser,   // [1:0] func
   // Response stream.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [31:0] page_addr, [33:32] status, rest zero
   // Managed page count register.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data     // [15:0] managed_pages
);

   pfba_cmd_type        cmd;
   pfba_stat_type       stat;
   logic [ADDR_W-1:0]   page_addr;
   logic [STATUS_W-1:0] status;
   logic                csr_write;

   // The register is taken on every cycle; ready is tied high.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   pfba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pfba_datapath #(
      .BITMAP_WORDS (BITMAP_WORDS),
      .PAGE_SHIFT   (PAGE_SHIFT)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_func      (req_tuser),
      .req_phys_addr (req_tdata[31:0]),
      .req_end_addr  (req_tdata[63:32]),
      .csr_valid     (csr_write),
      .csr_data      (csr_data),
      .rsp_page_addr (page_addr),
      .rsp_status    (status)
   );

   assign rsp_tdata = {6'b0, status, page_addr};

endmodule

`default_nettype wire
